@@ src/tcce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared geometry, codes, types and the address fold for the console engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Screen and memory geometry
    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int MEM_WORDS    = 8192;
    localparam int USED_WORDS   = (MEM_WORDS / COLS) * COLS;
    localparam int SCREEN_WORDS = COLS * ROWS;

    localparam int OFS_W  = 13;
    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CNT_W  = $clog2(SCREEN_WORDS);
    localparam int CH_W   = 8;
    localparam int CELL_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CELL_W-1:0] ERASE_RESET = 16'h0720;
    localparam logic [CH_W-1:0]   STYLE_RESET = 8'h07;

    // Control bytes
    localparam logic [CH_W-1:0] CH_NUL = 8'h00;
    localparam logic [CH_W-1:0] CH_BEL = 8'h07;
    localparam logic [CH_W-1:0] CH_BS  = 8'h08;
    localparam logic [CH_W-1:0] CH_HT  = 8'h09;
    localparam logic [CH_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CH_W-1:0] CH_DEL = 8'h7F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_STYLE = 1'b0,
        CFG_ERASE_CELL = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_READ,
        OP_BS,
        OP_HT,
        OP_LF,
        OP_CR,
        OP_DEL,
        OP_PRINT
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_NL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_ERASE,
        ST_POST,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  ch;
        logic [OFS_W-1:0] raddr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_q_t;

    typedef struct packed {
        logic clearing;
        logic take;
    } back_stat_t;

    // Fold a 13-bit word offset into the memory depth
    function automatic logic [ADDR_W-1:0] addr_of(input logic [OFS_W-1:0] ofs);
        logic [15:0] v;
        v = 16'(ofs);
        for (int k = 2; k >= 0; k--) begin
            if (v >= (16'(MEM_WORDS) << k)) begin
                v = v - (16'(MEM_WORDS) << k);
            end
        end
        return v[ADDR_W-1:0];
    endfunction

endpackage

@@ src/tcce_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_front
// Accept input beats, classify each byte into an operation, queue two deep.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      command,
    input  logic [7:0]                char_code,
    input  logic [12:0]               read_address,
    input  tcce_pkg::back_stat_t      stat,
    output tcce_pkg::cmd_q_t          q
);
    import tcce_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cmd_t       slot_reg [2];
    cmd_t       cls;
    logic       accept;
    logic       take;

    // Decode the byte
    always_comb
    begin
        cls.ch    = char_code;
        cls.raddr = read_address;
        if (command)
        begin
            cls.op = OP_READ;
        end
        else
        begin
            unique case (char_code) inside
                CH_NUL, CH_BEL, CH_VT, CH_FF: cls.op = OP_IGNORE;
                CH_BS:                        cls.op = OP_BS;
                CH_HT:                        cls.op = OP_HT;
                CH_LF:                        cls.op = OP_LF;
                CH_CR:                        cls.op = OP_CR;
                CH_DEL:                       cls.op = OP_DEL;
                default:                      cls.op = OP_PRINT;
            endcase
        end
    end

    assign full   = (cnt_reg == 2'd2) || stat.clearing;
    assign accept = push && !full;
    assign take   = stat.take && (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (take && !accept)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    assign q.valid = (cnt_reg != 2'd0);
    assign q.cmd   = slot_reg[rd_ptr_reg];

endmodule

@@ src/tcce_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_back
// Sequence queued operations over the cell memory; hold one result beat.
// ----------------------------------------------------------------------------
module tcce_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcce_pkg::cmd_q_t     q,
    output tcce_pkg::back_stat_t stat,
    input  logic [7:0]           text_style,
    input  logic [15:0]          erase_cell,
    input  logic                 pop,
    output logic                 empty,
    output logic [12:0]          cursor_offset,
    output logic [12:0]          screen_start,
    output logic [15:0]          read_data
);
    import tcce_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [OFS_W-1:0]  cur_reg, cur_next;
    logic [OFS_W-1:0]  win_reg, win_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    cmd_t              cmd_reg;

    logic [CELL_W-1:0] mem [MEM_WORDS];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [OFS_W-1:0]  mem_ofs;
    logic [ADDR_W-1:0] mem_addr;
    logic [CELL_W-1:0] mem_wdata;

    logic              res_valid_reg;
    logic [OFS_W-1:0]  res_cur_reg;
    logic [OFS_W-1:0]  res_win_reg;
    logic [CELL_W-1:0] res_data_reg;
    logic              slot_free;
    logic              res_load;
    logic              take;

    // Tab and wrap helpers
    logic [3:0]        tab_step;
    logic [COL_W:0]    tab_col;
    logic [OFS_W-1:0]  tab_cur;
    logic              tab_wrap;
    logic              row_room;
    logic              need_copy;
    logic              clr_last;
    logic              copy_last;
    logic              erase_last;

    assign tab_step   = 4'd8 - {1'b0, col_reg[2:0]};
    assign tab_col    = (COL_W+1)'(col_reg) + (COL_W+1)'(tab_step);
    assign tab_cur    = cur_reg + OFS_W'(tab_step);
    assign tab_wrap   = (tab_col >= (COL_W+1)'(COLS));
    assign row_room   = ((ROW_W+1)'(row_reg) + (ROW_W+1)'(1)) < (ROW_W+1)'(ROWS);
    assign need_copy  = (15'(win_reg) + 15'(SCREEN_WORDS + COLS)) >= 15'(USED_WORDS);
    assign clr_last   = (clr_reg == ADDR_W'(MEM_WORDS - 1));
    assign copy_last  = (cnt_reg == CNT_W'(SCREEN_WORDS - 1));
    assign erase_last = (cnt_reg == CNT_W'(COLS - 1));
    assign slot_free  = !res_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_last) state_next = ST_IDLE;
            ST_IDLE:    if (q.valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_LF:    state_next = ST_NL;
                    OP_HT:    state_next = tab_wrap ? ST_NL : ST_DONE;
                    OP_PRINT: state_next = (col_reg >= COL_W'(COLS)) ? ST_NL : ST_DONE;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_NL:
            begin
                if (row_room)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = need_copy ? ST_COPY_RD : ST_ERASE;
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: state_next = copy_last ? ST_ERASE : ST_COPY_RD;
            ST_ERASE:   if (erase_last) state_next = ST_POST;
            ST_POST:    state_next = ST_DONE;
            ST_DONE:    if (slot_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cur_next  = cur_reg;
        win_next  = win_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        cnt_next  = cnt_reg;
        clr_next  = clr_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_ofs   = cur_reg;
        mem_wdata = erase_cell;
        take      = 1'b0;
        res_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = ERASE_RESET;
                clr_next  = clr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                take = q.valid;
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_READ:
                    begin
                        mem_re  = 1'b1;
                        mem_ofs = cmd_reg.raddr;
                    end
                    OP_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - COL_W'(1);
                            cur_next = cur_reg - OFS_W'(1);
                            mem_we   = 1'b1;
                            mem_ofs  = cur_reg - OFS_W'(1);
                        end
                    end
                    OP_HT:
                    begin
                        if (tab_wrap)
                        begin
                            col_next = COL_W'(tab_col - (COL_W+1)'(COLS));
                            cur_next = tab_cur - OFS_W'(COLS);
                        end
                        else
                        begin
                            col_next = COL_W'(tab_col);
                            cur_next = tab_cur;
                        end
                    end
                    OP_CR:
                    begin
                        cur_next = cur_reg - OFS_W'(col_reg);
                        col_next = '0;
                    end
                    OP_DEL:
                    begin
                        mem_we = 1'b1;
                    end
                    OP_PRINT:
                    begin
                        if (col_reg >= COL_W'(COLS))
                        begin
                            // pending wrap: step back to the line start, new line follows
                            col_next = col_reg - COL_W'(COLS);
                            cur_next = cur_reg - OFS_W'(COLS);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {text_style, cmd_reg.ch};
                            cur_next  = cur_reg + OFS_W'(1);
                            col_next  = col_reg + COL_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_NL:
            begin
                cnt_next = '0;
                if (row_room)
                begin
                    row_next = row_reg + ROW_W'(1);
                    cur_next = cur_reg + OFS_W'(COLS);
                end
            end
            ST_COPY_RD:
            begin
                mem_re  = 1'b1;
                mem_ofs = win_reg + OFS_W'(cnt_reg);
            end
            ST_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_ofs   = OFS_W'(cnt_reg);
                mem_wdata = rdata_reg;
                if (copy_last)
                begin
                    cnt_next = '0;
                    cur_next = cur_reg - win_reg;
                    win_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ERASE:
            begin
                mem_we  = 1'b1;
                mem_ofs = OFS_W'(15'(win_reg) + 15'(SCREEN_WORDS) + 15'(cnt_reg));
                if (erase_last)
                begin
                    win_next = win_reg + OFS_W'(COLS);
                    cur_next = cur_reg + OFS_W'(COLS);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_POST:
            begin
                if (cmd_reg.op == OP_LF)
                begin
                    cur_next = cur_reg - OFS_W'(col_reg);
                    col_next = '0;
                end
                else if (cmd_reg.op == OP_PRINT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {text_style, cmd_reg.ch};
                    cur_next  = cur_reg + OFS_W'(1);
                    col_next  = col_reg + COL_W'(1);
                end
            end
            ST_DONE:
            begin
                res_load = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    assign mem_addr = (state_reg == ST_CLEAR) ? clr_reg : addr_of(mem_ofs);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            win_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            win_reg   <= win_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= q.cmd;
        end
        if (res_load)
        begin
            res_cur_reg  <= cur_reg;
            res_win_reg  <= win_reg;
            res_data_reg <= (cmd_reg.op == OP_READ) ? rdata_reg : '0;
        end
    end

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.take     = take;
    assign empty         = !res_valid_reg;
    assign cursor_offset = res_cur_reg;
    assign screen_start  = res_win_reg;
    assign read_data     = res_data_reg;

endmodule

@@ src/text_console_character_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text-mode console: byte commands, cell reads and CRTC offsets per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive command, char_code and read_address and
//   raise push; the beat is taken on a clock where full is low. Results come
//   out of a one-beat queue: while empty is low the oldest result stands on
//   cursor_offset, screen_start and read_data, and pop takes it.
//   Config writes (cfg_valid, always ready) set the text style or the erase
//   word; write them only while the engine is idle.
//   A cell read, a printable byte or a control code that stays on the line
//   runs through EXEC and DONE; a new line (LF, a wrapping tab, a printable
//   byte after a pending wrap) also runs NL and POST. On the last row the
//   row erase (ERASE, one cell per column) comes before POST; when the
//   window reaches the end of memory the screen is first copied down, each
//   word read and then written (COPY_RD, COPY_WR). The sequential back end
//   works on one beat at a time over the single-port cell memory, while
//   the input queue can take further beats.
//   Reset: the memory is swept with the reset erase word, one word a cycle
//   (MEM_WORDS words, 8192 by default); full stays high during the sweep.
//   Stalls: with no pop the result holds and up to two more beats queue up
//   at the input before full rises.
// ----------------------------------------------------------------------------
module text_console_character_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  char_code,
    input  logic [12:0] read_address,
    output logic        empty,
    input  logic        pop,
    output logic [12:0] cursor_offset,
    output logic [12:0] screen_start,
    output logic [15:0] read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tcce_pkg::*;

    logic [CH_W-1:0]   text_style_reg;
    logic [CELL_W-1:0] erase_cell_reg;
    back_stat_t        stat;
    cmd_q_t            q;

    // Config registers take every beat; unknown indexes drop
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_style_reg <= STYLE_RESET;
            erase_cell_reg <= ERASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEXT_STYLE: text_style_reg <= cfg_data[CH_W-1:0];
                CFG_ERASE_CELL: erase_cell_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: classify and queue the byte stream
    tcce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .char_code    (char_code),
        .read_address (read_address),
        .stat         (stat),
        .q            (q)
    );

    // Back: run the cursor, scroll and memory sequencer
    tcce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q             (q),
        .stat          (stat),
        .text_style    (text_style_reg),
        .erase_cell    (erase_cell_reg),
        .pop           (pop),
        .empty         (empty),
        .cursor_offset (cursor_offset),
        .screen_start  (screen_start),
        .read_data     (read_data)
    );

endmodule
